FILE: sv/lqf_pkg.sv
// Shared types and constants for the linked queue with free list.
// Used by the controller, the datapath and the top level; no dependencies.
package lqf_pkg;

   localparam int WORD_WIDTH = 32;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENQ_READ,
      ST_ENQ_LINK,
      ST_ENQ_TAIL,
      ST_DEQ_READ,
      ST_DEQ_LINK,
      ST_DEQ_DATA,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load_item;
      logic enq_read;
      logic enq_link;
      logic enq_tail;
      logic deq_read;
      logic deq_link;
      logic deq_data;
      logic resp_load;
   } ctrl_type;

   typedef struct packed {
      logic free_ok;
      logic head_ok;
      logic link_ok;
      logic rsp_busy;
   } stat_type;

endpackage

FILE: sv/linked_queue_with_free_list_core.sv
// FIFO queue kept as a linked list over DEPTH nodes, with the unused nodes on a
// free list; each item (enqueue a word or dequeue the front) gives one result
// carrying accepted, the new front word, empty and full. Depends on lqf_pkg,
// lqf_ctrl and lqf_dp. A refused item (enqueue on full, dequeue on empty) goes
// straight to its result; an enqueue links the free-list head in behind the
// tail (or as the front, if the queue was empty); a dequeue frees the front
// node and loads the next front word, if any. No clearing pass is needed after
// reset: nodes never yet handed out are tracked by a fill count. A finished
// result waits in an output register while the next item is taken.
module linked_queue_with_free_list_core #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [lqf_pkg::WORD_WIDTH-1:0] req_enqueue_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_accepted,
   output logic                           rsp_front_valid,
   output logic [lqf_pkg::WORD_WIDTH-1:0] rsp_front_data,
   output logic                           rsp_queue_empty,
   output logic                           rsp_queue_full
);
   import lqf_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   lqf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   lqf_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_enqueue_data (req_enqueue_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_front_valid  (rsp_front_valid),
      .rsp_front_data   (rsp_front_data),
      .rsp_queue_empty  (rsp_queue_empty),
      .rsp_queue_full   (rsp_queue_full)
   );

endmodule

FILE: sv/lqf_ctrl.sv
// Sequencer for the linked queue: steps each item through the link memory.
// Depends on lqf_pkg; drives the datapath by commands, reads its status.
module lqf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_cmd,
   output logic              req_stall,
   input  lqf_pkg::stat_type stat,
   output lqf_pkg::ctrl_type ctrl
);
   import lqf_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.load_item = 1'b1;
               if (req_cmd == CMD_ENQUEUE) begin
                  state_in = stat.free_ok ? ST_ENQ_READ : ST_RESP;
               end else begin
                  state_in = stat.head_ok ? ST_DEQ_READ : ST_RESP;
               end
            end
         end
         ST_ENQ_READ: begin
            ctrl.enq_read = 1'b1;
            state_in      = ST_ENQ_LINK;
         end
         ST_ENQ_LINK: begin
            ctrl.enq_link = 1'b1;
            state_in      = stat.head_ok ? ST_ENQ_TAIL : ST_RESP;
         end
         ST_ENQ_TAIL: begin
            ctrl.enq_tail = 1'b1;
            state_in      = ST_RESP;
         end
         ST_DEQ_READ: begin
            ctrl.deq_read = 1'b1;
            state_in      = ST_DEQ_LINK;
         end
         ST_DEQ_LINK: begin
            ctrl.deq_link = 1'b1;
            state_in      = stat.link_ok ? ST_DEQ_DATA : ST_RESP;
         end
         ST_DEQ_DATA: begin
            ctrl.deq_data = 1'b1;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (!stat.rsp_busy) begin
               ctrl.resp_load = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/lqf_dp.sv
// Datapath of the linked queue: node memories, list pointers, result register.
// Depends on lqf_pkg; follows the commands of lqf_ctrl.
module lqf_dp #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lqf_pkg::ctrl_type                 ctrl,
   output lqf_pkg::stat_type                 stat,
   input  logic [lqf_pkg::WORD_WIDTH-1:0]    req_enqueue_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_accepted,
   output logic                              rsp_front_valid,
   output logic [lqf_pkg::WORD_WIDTH-1:0]    rsp_front_data,
   output logic                              rsp_queue_empty,
   output logic                              rsp_queue_full
);
   import lqf_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DATA_WIDTH-1:0] data_mem [DEPTH];
   logic [AW:0]           next_mem [DEPTH];

   logic [DATA_WIDTH-1:0] item_data_ff;
   logic [DATA_WIDTH-1:0] front_ff;
   logic [DATA_WIDTH-1:0] data_rd_ff;
   logic [AW:0]           next_rd_ff;
   logic [AW-1:0]         alloc_ff;

   logic [AW-1:0] free_head_ff;
   logic          free_ok_ff;
   logic [AW-1:0] head_ff;
   logic          head_ok_ff;
   logic [AW-1:0] tail_ff;
   logic [AW:0]   fresh_cnt_ff;
   logic          accepted_ff;

   logic          rsp_valid_ff;
   logic          rsp_accepted_ff;
   logic          rsp_front_valid_ff;
   logic [WORD_WIDTH-1:0] rsp_front_data_ff;
   logic          rsp_queue_empty_ff;
   logic          rsp_queue_full_ff;

   logic          fresh;
   logic [AW:0]   alloc_link;
   logic          next_we;
   logic [AW-1:0] next_waddr;
   logic [AW:0]   next_wdata;
   logic [AW-1:0] next_raddr;

   assign fresh      = {1'b0, alloc_ff} < fresh_cnt_ff;
   assign alloc_link = fresh ? {alloc_ff != '0, alloc_ff - 1'b1} : next_rd_ff;
   assign next_raddr = ctrl.enq_read ? free_head_ff : head_ff;

   always_comb begin
      next_we    = 1'b0;
      next_waddr = alloc_ff;
      next_wdata = '0;
      if (ctrl.enq_link) begin
         next_we = 1'b1;
      end else if (ctrl.enq_tail) begin
         next_we    = 1'b1;
         next_waddr = tail_ff;
         next_wdata = {1'b1, alloc_ff};
      end else if (ctrl.deq_link) begin
         next_we    = 1'b1;
         next_wdata = {free_ok_ff, free_head_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.enq_read) begin
         data_mem[free_head_ff] <= item_data_ff;
      end
      if (ctrl.deq_link) begin
         data_rd_ff <= data_mem[next_rd_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (ctrl.enq_read || ctrl.deq_read) begin
         next_rd_ff <= next_mem[next_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_item) begin
         item_data_ff <= DATA_WIDTH'(req_enqueue_data);
      end
      if (ctrl.enq_read) begin
         alloc_ff <= free_head_ff;
      end else if (ctrl.deq_read) begin
         alloc_ff <= head_ff;
      end
      if (ctrl.enq_link && !head_ok_ff) begin
         front_ff <= item_data_ff;
      end else if (ctrl.deq_data) begin
         front_ff <= data_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= AW'(DEPTH - 1);
         free_ok_ff   <= 1'b1;
         head_ff      <= '0;
         head_ok_ff   <= 1'b0;
         tail_ff      <= '0;
         fresh_cnt_ff <= (AW + 1)'(DEPTH);
         accepted_ff  <= 1'b0;
      end else begin
         if (ctrl.load_item) begin
            accepted_ff <= 1'b0;
         end
         if (ctrl.enq_read || ctrl.deq_read) begin
            accepted_ff <= 1'b1;
         end
         if (ctrl.enq_link) begin
            free_head_ff <= alloc_link[AW-1:0];
            free_ok_ff   <= alloc_link[AW];
            if (fresh) begin
               fresh_cnt_ff <= fresh_cnt_ff - (AW + 1)'(1);
            end
            if (!head_ok_ff) begin
               head_ff    <= alloc_ff;
               tail_ff    <= alloc_ff;
               head_ok_ff <= 1'b1;
            end
         end
         if (ctrl.enq_tail) begin
            tail_ff <= alloc_ff;
         end
         if (ctrl.deq_link) begin
            free_head_ff <= alloc_ff;
            free_ok_ff   <= 1'b1;
            head_ok_ff   <= next_rd_ff[AW];
            if (next_rd_ff[AW]) begin
               head_ff <= next_rd_ff[AW-1:0];
            end else begin
               head_ff <= '0;
               tail_ff <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.resp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.resp_load) begin
         rsp_accepted_ff    <= accepted_ff;
         rsp_front_valid_ff <= head_ok_ff;
         rsp_front_data_ff  <= head_ok_ff ? WORD_WIDTH'(front_ff) : '0;
         rsp_queue_empty_ff <= !head_ok_ff;
         rsp_queue_full_ff  <= !free_ok_ff;
      end
   end

   assign stat.free_ok  = free_ok_ff;
   assign stat.head_ok  = head_ok_ff;
   assign stat.link_ok  = next_rd_ff[AW];
   assign stat.rsp_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_front_valid = rsp_front_valid_ff;
   assign rsp_front_data  = rsp_front_data_ff;
   assign rsp_queue_empty = rsp_queue_empty_ff;
   assign rsp_queue_full  = rsp_queue_full_ff;

endmodule
